// ===== sv/lla_pkg.sv =====
`timescale 1ns / 1ps

package lla_pkg;

	// field and register widths
	localparam int OP_W       = 2;
	localparam int ROW_W      = 7;
	localparam int COL_W      = 8;
	localparam int POP_W      = 16;
	localparam int MASK_W     = 9;
	localparam int ROWS_CFG_W = 8;
	localparam int COLS_CFG_W = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// default grid bounds
	localparam int DEF_ROWS_CAP = 128;
	localparam int DEF_COLS_CAP = 256;

	// register reset values: born on three, survive on two or three
	localparam logic [MASK_W-1:0]     BIRTH_RST   = 9'd8;
	localparam logic [MASK_W-1:0]     SURVIVE_RST = 9'd12;
	localparam logic [ROWS_CFG_W-1:0] ROWS_RST    = 8'd128;
	localparam logic [COLS_CFG_W-1:0] COLS_RST    = 9'd256;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_STEP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIRTH   = 2'd0,
		CFG_SURVIVE = 2'd1,
		CFG_ROWS    = 2'd2,
		CFG_COLS    = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_MOD,
		ST_CWRITE,
		ST_CREAD,
		ST_CRWAIT,
		ST_GLOAD,
		ST_GLWAIT,
		ST_GCELL,
		ST_GWRITE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic capture;
		logic mod_step;
		logic cell_write;
		logic item_read;
		logic bit_capture;
		logic gen_init;
		logic load_step;
		logic cell_step;
		logic row_write;
		logic flip;
		logic out_load;
		logic clear_step;
	} lla_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic mod_last;
		logic load_last;
		logic col_last;
		logic row_last;
		logic out_blocked;
		op_t  op;
	} lla_stat_t;

endpackage

// ===== sv/lla_board_mem.sv =====
`timescale 1ns / 1ps

module lla_board_mem import lla_pkg::*; #(
	parameter int ROWS_CAP = DEF_ROWS_CAP,
	parameter int COLS_CAP = DEF_COLS_CAP
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((ROWS_CAP > 1) ? $clog2(ROWS_CAP) : 1):0] waddr,
	input  logic [COLS_CAP-1:0]                         wdata,
	input  logic [COLS_CAP-1:0]                         wmask,
	input  logic                                        re,
	input  logic [((ROWS_CAP > 1) ? $clog2(ROWS_CAP) : 1):0] raddr,
	output logic [COLS_CAP-1:0]                         rdata
);

	localparam int RAW   = (ROWS_CAP > 1) ? $clog2(ROWS_CAP) : 1;
	localparam int DEPTH = 2 ** (RAW + 1);

	// one row of one board per word, board select is the address msb
	logic [COLS_CAP-1:0] mem [DEPTH];
	logic [COLS_CAP-1:0] rdata_q;

	// bit-masked write port
	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < COLS_CAP; i++) begin
				if (wmask[i]) begin
					mem[waddr][i] <= wdata[i];
				end
			end
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/lla_datapath.sv =====
`timescale 1ns / 1ps

module lla_datapath import lla_pkg::*; #(
	parameter int ROWS_CAP = DEF_ROWS_CAP,
	parameter int COLS_CAP = DEF_COLS_CAP
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lla_cmd_t              cmd,
	output lla_stat_t             stat,
	input  logic [OP_W-1:0]       op,
	input  logic [ROW_W-1:0]      row,
	input  logic [COL_W-1:0]      col,
	input  logic                  cell_in,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  cell_out,
	output logic [POP_W-1:0]      population
);

	localparam int RAW  = (ROWS_CAP > 1) ? $clog2(ROWS_CAP) : 1;
	localparam int CAW  = (COLS_CAP > 1) ? $clog2(COLS_CAP) : 1;
	localparam int RIW  = $clog2(ROWS_CAP + 1);
	localparam int CIW  = $clog2(COLS_CAP + 1);
	localparam int RCW  = (RIW > ROWS_CFG_W) ? RIW : ROWS_CFG_W;
	localparam int CCW  = (CIW > COLS_CFG_W) ? CIW : COLS_CFG_W;
	localparam int MCW  = $clog2(COL_W);

	// configuration registers
	logic [MASK_W-1:0]     birth_q, survive_q;
	logic [ROWS_CFG_W-1:0] rows_q;
	logic [COLS_CFG_W-1:0] cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q   <= BIRTH_RST;
			survive_q <= SURVIVE_RST;
			rows_q    <= ROWS_RST;
			cols_q    <= COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BIRTH:   birth_q   <= cfg_data;
				CFG_SURVIVE: survive_q <= cfg_data;
				CFG_ROWS:    rows_q    <= cfg_data[ROWS_CFG_W-1:0];
				CFG_COLS:    cols_q    <= cfg_data[COLS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// grid size clamped to 1..max
	logic [RIW-1:0] h, hm1;
	logic [CIW-1:0] w, wm1;

	always_comb begin
		if (rows_q == '0) h = RIW'(1);
		else if (RCW'(rows_q) > RCW'(ROWS_CAP)) h = RIW'(ROWS_CAP);
		else h = RIW'(rows_q);
		if (cols_q == '0) w = CIW'(1);
		else if (CCW'(cols_q) > CCW'(COLS_CAP)) w = CIW'(COLS_CAP);
		else w = CIW'(cols_q);
		hm1 = h - RIW'(1);
		wm1 = w - CIW'(1);
	end

	// captured item
	op_t             op_q;
	logic            cell_q;
	logic [COL_W-1:0] rnum_q, cnum_q;
	logic [RIW-1:0]  rrem_q;
	logic [CIW-1:0]  crem_q;
	logic [MCW-1:0]  mcnt_q;
	logic [RIW:0]    rtry, rsub;
	logic [CIW:0]    ctry, csub;

	// restoring remainder, one numerator bit per cycle for row and column
	always_comb begin
		rtry = {rrem_q, rnum_q[COL_W-1]};
		ctry = {crem_q, cnum_q[COL_W-1]};
		rsub = rtry - {1'b0, h};
		csub = ctry - {1'b0, w};
		if (rtry < {1'b0, h}) rsub = rtry;
		if (ctry < {1'b0, w}) csub = ctry;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(op);
			cell_q <= cell_in;
			rnum_q <= COL_W'(row);
			cnum_q <= col;
			rrem_q <= '0;
			crem_q <= '0;
			mcnt_q <= '0;
		end else if (cmd.mod_step) begin
			rnum_q <= {rnum_q[COL_W-2:0], 1'b0};
			cnum_q <= {cnum_q[COL_W-2:0], 1'b0};
			rrem_q <= rsub[RIW-1:0];
			crem_q <= csub[CIW-1:0];
			mcnt_q <= mcnt_q + MCW'(1);
		end
	end

	logic [RAW-1:0] item_r;
	logic [CAW-1:0] item_c;
	assign item_r = rrem_q[RAW-1:0];
	assign item_c = crem_q[CAW-1:0];

	// board select and clearing sweep
	logic         sel_q;
	logic [RAW:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			clr_q <= '0;
		end else begin
			if (cmd.flip) sel_q <= ~sel_q;
			if (cmd.clear_step) clr_q <= clr_q + (RAW+1)'(1);
		end
	end

	// generation counters and row window
	logic [RAW-1:0]      gr_q;
	logic [CAW-1:0]      gc_q;
	logic [1:0]          k_q, slot_s1;
	logic                slot_v_s1;
	logic [COLS_CAP-1:0] above_q, mid_q, below_q, new_q;
	logic [POP_W-1:0]    pop_q;
	logic                rbit_q;
	logic [COLS_CAP-1:0] rdata;

	logic [RAW-1:0] ru, rd, lrow;
	logic [CAW-1:0] cl, cr;
	logic [3:0]     ncount;
	logic [MASK_W-1:0] rule;
	logic           nv;

	// wrapped neighbor coordinates and next cell value
	always_comb begin
		ru = (gr_q == '0) ? hm1[RAW-1:0] : gr_q - RAW'(1);
		rd = (RIW'(gr_q) == hm1) ? '0 : gr_q + RAW'(1);
		cl = (gc_q == '0) ? wm1[CAW-1:0] : gc_q - CAW'(1);
		cr = (CIW'(gc_q) == wm1) ? '0 : gc_q + CAW'(1);
		case (k_q)
			2'd0:    lrow = ru;
			2'd1:    lrow = gr_q;
			default: lrow = rd;
		endcase
		ncount = 4'($countones({above_q[cl], above_q[gc_q], above_q[cr],
			mid_q[cl], mid_q[cr], below_q[cl], below_q[gc_q], below_q[cr]}));
		rule = mid_q[gc_q] ? survive_q : birth_q;
		nv = (ncount < 4'(MASK_W)) ? rule[ncount] : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_v_s1 <= 1'b0;
		end else begin
			slot_v_s1 <= cmd.load_step;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= k_q;
		if (slot_v_s1) begin
			case (slot_s1)
				2'd0:    above_q <= rdata;
				2'd1:    mid_q   <= rdata;
				default: below_q <= rdata;
			endcase
		end
		if (cmd.gen_init) begin
			gr_q  <= '0;
			gc_q  <= '0;
			k_q   <= '0;
			pop_q <= '0;
		end else begin
			if (cmd.load_step) k_q <= k_q + 2'd1;
			if (cmd.cell_step) begin
				new_q[gc_q] <= nv;
				gc_q <= gc_q + CAW'(1);
				if (nv && pop_q != '1) pop_q <= pop_q + POP_W'(1);
			end
			if (cmd.row_write) begin
				gr_q <= gr_q + RAW'(1);
				gc_q <= '0;
				k_q  <= '0;
			end
		end
		if (cmd.bit_capture) rbit_q <= rdata[item_c];
	end

	// memory port steering
	logic                mem_we, mem_re;
	logic [RAW:0]        waddr, raddr;
	logic [COLS_CAP-1:0] wdata, wmask;

	always_comb begin
		mem_we = cmd.clear_step | cmd.cell_write | cmd.row_write;
		mem_re = cmd.item_read | cmd.load_step;
		waddr  = clr_q;
		wdata  = '0;
		wmask  = '1;
		if (cmd.cell_write) begin
			waddr = {sel_q, item_r};
			wdata = {COLS_CAP{cell_q}};
			for (int i = 0; i < COLS_CAP; i++) wmask[i] = (CAW'(i) == item_c);
		end else if (cmd.row_write) begin
			waddr = {~sel_q, gr_q};
			wdata = new_q;
			for (int i = 0; i < COLS_CAP; i++) wmask[i] = (CIW'(i) < w);
		end
		raddr = cmd.item_read ? {sel_q, item_r} : {sel_q, lrow};
	end

	lla_board_mem #(
		.ROWS_CAP(ROWS_CAP),
		.COLS_CAP(COLS_CAP)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.wmask (wmask),
		.re    (mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result register
	logic             out_valid_q, cell_out_q;
	logic [POP_W-1:0] pop_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_out_q <= (op_q == OP_READ) ? rbit_q : 1'b0;
			pop_out_q  <= (op_q == OP_STEP) ? pop_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_out   = cell_out_q;
	assign population = pop_out_q;

	// status to the controller
	always_comb begin
		stat.clear_last  = (clr_q == '1);
		stat.mod_last    = (mcnt_q == MCW'(COL_W - 1));
		stat.load_last   = (k_q == 2'd2);
		stat.col_last    = (CIW'(gc_q) == wm1);
		stat.row_last    = (RIW'(gr_q) == hm1);
		stat.out_blocked = out_valid_q & ~out_ready;
		stat.op          = op_q;
	end

endmodule

// ===== sv/lla_ctrl.sv =====
`timescale 1ns / 1ps

module lla_ctrl import lla_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lla_stat_t stat,
	output lla_cmd_t  cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.op)
					OP_WRITE, OP_READ: state_d = ST_MOD;
					OP_STEP: begin
						cmd.gen_init = 1'b1;
						state_d      = ST_GLOAD;
					end
					default: state_d = ST_RESP;
				endcase
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) state_d = (stat.op == OP_WRITE) ? ST_CWRITE : ST_CREAD;
			end
			ST_CWRITE: begin
				cmd.cell_write = 1'b1;
				state_d        = ST_RESP;
			end
			ST_CREAD: begin
				cmd.item_read = 1'b1;
				state_d       = ST_CRWAIT;
			end
			ST_CRWAIT: begin
				cmd.bit_capture = 1'b1;
				state_d         = ST_RESP;
			end
			ST_GLOAD: begin
				cmd.load_step = 1'b1;
				if (stat.load_last) state_d = ST_GLWAIT;
			end
			ST_GLWAIT: state_d = ST_GCELL;
			ST_GCELL: begin
				cmd.cell_step = 1'b1;
				if (stat.col_last) state_d = ST_GWRITE;
			end
			ST_GWRITE: begin
				cmd.row_write = 1'b1;
				if (stat.row_last) begin
					cmd.flip = 1'b1;
					state_d  = ST_RESP;
				end else begin
					state_d = ST_GLOAD;
				end
			end
			ST_RESP: begin
				if (!stat.out_blocked) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

// ===== sv/life_like_automaton_generation_unit.sv =====
`timescale 1ns / 1ps

// Life-like automaton on a wrapped grid held in two row-wide boards. After reset
// the boards are swept to dead, one row of one board per cycle, before in_ready
// rises. A cell write or read first runs the bit-serial remainder unit that wraps
// row and col (8 steps). In a generation, each row loads three rows through the
// single read port, visits one cell per cycle, then writes the new row back. One
// transaction is worked on at a time; a finished result waits in the output
// register while the next is accepted.
module life_like_automaton_generation_unit import lla_pkg::*; #(
	parameter int MAX_GRID_ROWS = DEF_ROWS_CAP,
	parameter int MAX_GRID_COLS = DEF_COLS_CAP
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OP_W-1:0]       op,
	input  logic [ROW_W-1:0]      row,
	input  logic [COL_W-1:0]      col,
	input  logic                  cell_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  cell_out,
	output logic [POP_W-1:0]      population,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lla_cmd_t  cmd;
	lla_stat_t stat;

	assign cfg_ready = 1'b1;

	lla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lla_datapath #(
		.ROWS_CAP(MAX_GRID_ROWS),
		.COLS_CAP(MAX_GRID_COLS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (op),
		.row        (row),
		.col        (col),
		.cell_in    (cell_in),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.cell_out   (cell_out),
		.population (population)
	);

	// one transaction in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous transaction in flight");

	// a result never carries both a cell value and a population
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(cell_out && population != '0))
		else $error("result mixes read and step fields");

	// a result is loaded only from the response state, never mid-generation
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !cmd.cell_step && !cmd.row_write && !stat.out_blocked)
		else $error("result loaded while busy or blocked");

endmodule

// ===== bench/life_like_automaton_generation_unit_tb.sv =====
`timescale 1ns / 1ps

module life_like_automaton_generation_unit_tb;
	import lla_pkg::*;

	localparam int GRID_ROWS = DEF_ROWS_CAP;
	localparam int GRID_COLS = DEF_COLS_CAP;
	localparam int STALL_LIMIT = 150000;
	localparam int SETTLE_CYCLES = 8;

	typedef enum logic [1:0] {
		E_ITEM,
		E_REG,
		E_DRAIN
	} entry_kind_t;

	typedef struct {
		entry_kind_t      kind;
		op_t              op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             alive;
		cfg_idx_t         idx;
		logic [CFG_DATA_W-1:0] data;
	} entry_t;

	typedef struct {
		logic             alive;
		logic [POP_W-1:0] pop;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] op = '0;
	logic [ROW_W-1:0] row = '0;
	logic [COL_W-1:0] col = '0;
	logic cell_in = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic cell_out;
	logic [POP_W-1:0] population;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	entry_t pending_entries[$];
	cell_result_t expected_cells[$];
	int errors = 0;
	int items_sent = 0;
	int steps_sent = 0;
	int regs_written = 0;
	int results_seen = 0;

	// mirror of the grid and the registers
	bit grid_mirror [0:1][0:GRID_ROWS-1][0:GRID_COLS-1];
	bit mirror_sel = 1'b0;
	logic [MASK_W-1:0] born_mask = BIRTH_RST;
	logic [MASK_W-1:0] live_mask = SURVIVE_RST;
	logic [ROWS_CFG_W-1:0] rows_reg = ROWS_RST;
	logic [COLS_CFG_W-1:0] cols_reg = COLS_RST;

	life_like_automaton_generation_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .row(row), .col(col), .cell_in(cell_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_out(cell_out), .population(population),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int used_rows();
		if (rows_reg == 0) return 1;
		if (rows_reg > GRID_ROWS) return GRID_ROWS;
		return rows_reg;
	endfunction

	function automatic int used_cols();
		if (cols_reg == 0) return 1;
		if (cols_reg > GRID_COLS) return GRID_COLS;
		return cols_reg;
	endfunction

	// one generation over the in-use area, returns saturated population
	function automatic logic [POP_W-1:0] advance_generation();
		int h, w, cur, nxt, pop, n, ru, rd, cl, cr;
		bit v;
		h = used_rows();
		w = used_cols();
		cur = mirror_sel;
		nxt = !mirror_sel;
		pop = 0;
		for (int r = 0; r < h; r++) begin
			ru = (r + h - 1) % h;
			rd = (r + 1) % h;
			for (int c = 0; c < w; c++) begin
				cl = (c + w - 1) % w;
				cr = (c + 1) % w;
				n = grid_mirror[cur][ru][cl] + grid_mirror[cur][ru][c]
					+ grid_mirror[cur][ru][cr] + grid_mirror[cur][r][cl]
					+ grid_mirror[cur][r][cr] + grid_mirror[cur][rd][cl]
					+ grid_mirror[cur][rd][c] + grid_mirror[cur][rd][cr];
				v = grid_mirror[cur][r][c] ? live_mask[n] : born_mask[n];
				grid_mirror[nxt][r][c] = v;
				pop += v;
			end
		end
		mirror_sel = !mirror_sel;
		return (pop > 65535) ? 16'hFFFF : pop[POP_W-1:0];
	endfunction

	function automatic cell_result_t predict_transaction(entry_t e);
		cell_result_t res;
		int r, c;
		r = e.row % used_rows();
		c = e.col % used_cols();
		res.alive = 1'b0;
		res.pop = '0;
		case (e.op)
			OP_WRITE: grid_mirror[mirror_sel][r][c] = e.alive;
			OP_READ: res.alive = grid_mirror[mirror_sel][r][c];
			OP_STEP: res.pop = advance_generation();
			default: ;
		endcase
		return res;
	endfunction

	function automatic void apply_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_BIRTH: born_mask = d;
			CFG_SURVIVE: live_mask = d;
			CFG_ROWS: rows_reg = d[ROWS_CFG_W-1:0];
			CFG_COLS: cols_reg = d;
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// driver: feeds transactions and register writes from the pending queue
	int send_gap = 0;
	int quiet_cycles = 0;
	int idle_count = 0;
	always @(posedge clk) begin
		logic nv, cv;
		entry_t head;
		nv = in_valid;
		cv = cfg_valid;
		if (arst_n) begin
			if (expected_cells.size() == 0 && !in_valid) idle_count++;
			else idle_count = 0;
			if (in_valid && in_ready) begin
				expected_cells.push_back(predict_transaction(pending_entries[0]));
				if (pending_entries[0].op == OP_STEP) steps_sent++;
				items_sent++;
				pending_entries.pop_front();
				nv = 1'b0;
				idle_count = 0;
			end
			if (cfg_valid && cfg_ready) begin
				apply_register(pending_entries[0].idx, pending_entries[0].data);
				regs_written++;
				pending_entries.pop_front();
				cv = 1'b0;
			end
			if (!nv && !cv && pending_entries.size() > 0) begin
				head = pending_entries[0];
				if (send_gap > 0) begin
					send_gap--;
				end else if (head.kind == E_ITEM) begin
					nv = 1'b1;
					op <= head.op;
					row <= head.row;
					col <= head.col;
					cell_in <= head.alive;
					if (quiet_cycles > 0) begin
						quiet_cycles--;
						send_gap = 0;
					end else begin
						send_gap = pick_gap();
						if ($urandom_range(0, 15) == 0) quiet_cycles = 12;
					end
				end else if (idle_count >= SETTLE_CYCLES) begin
					if (head.kind == E_REG) begin
						cv = 1'b1;
						cfg_index <= head.idx;
						cfg_data <= head.data;
					end else begin
						pending_entries.pop_front();
					end
				end
			end
		end
		in_valid <= nv;
		cfg_valid <= cv;
	end

	// monitor: random back-pressure and result checking
	int recv_gap = 0;
	always @(posedge clk) begin
		logic nr;
		cell_result_t want;
		nr = out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_cells.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_cells.pop_front();
					if (cell_out !== want.alive) report_mismatch("cell_out", cell_out, want.alive);
					if (population !== want.pop) report_mismatch("population", population, want.pop);
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
				if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
			end
		end
		out_ready <= nr;
	end

	// watchdog on cycles without any handshake on the input, output or register port
	int stall_count = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_cells.size());
			$display("** life_like_automaton_generation_unit: FAILED **");
			$finish;
		end
	end

	task automatic push_item(op_t o, int r, int c, bit v);
		entry_t e;
		e.kind = E_ITEM;
		e.op = o;
		e.row = ROW_W'(r);
		e.col = COL_W'(c);
		e.alive = v;
		e.idx = CFG_BIRTH;
		e.data = '0;
		pending_entries.push_back(e);
	endtask

	task automatic push_reg(cfg_idx_t i, int d);
		entry_t e;
		e.kind = E_REG;
		e.op = OP_NONE;
		e.row = '0;
		e.col = '0;
		e.alive = 1'b0;
		e.idx = i;
		e.data = CFG_DATA_W'(d);
		pending_entries.push_back(e);
	endtask

	task automatic push_drain();
		entry_t e;
		e.kind = E_DRAIN;
		e.op = OP_NONE;
		e.row = '0;
		e.col = '0;
		e.alive = 1'b0;
		e.idx = CFG_BIRTH;
		e.data = '0;
		pending_entries.push_back(e);
	endtask

	initial begin
		int n, sel, wait_cycles;
		op_t o;

		// defaults: glider on the full grid, corners, unused opcode
		push_item(OP_WRITE, 1, 2, 1);
		push_item(OP_WRITE, 2, 3, 1);
		push_item(OP_WRITE, 3, 1, 1);
		push_item(OP_WRITE, 3, 2, 1);
		push_item(OP_WRITE, 3, 3, 1);
		push_item(OP_WRITE, 127, 255, 1);
		push_item(OP_READ, 2, 3, 0);
		push_item(OP_READ, 127, 255, 1);
		push_item(OP_READ, 0, 0, 0);
		push_item(OP_STEP, 127, 255, 1);
		push_item(OP_READ, 3, 2, 0);
		push_item(OP_NONE, $urandom_range(0, 127), $urandom_range(0, 255), 1);
		push_item(OP_WRITE, 127, 255, 0);
		push_drain();
		// mask extremes and zero-sized grid
		push_reg(CFG_BIRTH, 511);
		push_reg(CFG_SURVIVE, 0);
		push_reg(CFG_ROWS, 0);
		push_reg(CFG_COLS, 0);
		push_item(OP_WRITE, 5, 7, 1);
		push_item(OP_READ, 0, 0, 0);
		push_item(OP_STEP, 0, 0, 0);
		push_item(OP_STEP, 0, 0, 0);
		// oversized values clamp; cells outside the small area kept their contents
		push_reg(CFG_ROWS, 511);
		push_reg(CFG_COLS, 511);
		push_item(OP_READ, 3, 3, 0);
		push_reg(CFG_BIRTH, BIRTH_RST);
		push_reg(CFG_SURVIVE, SURVIVE_RST);
		push_reg(CFG_ROWS, 3);
		push_reg(CFG_COLS, 5);
		// address wrap on a small grid
		push_item(OP_WRITE, 100, 200, 1);
		push_item(OP_READ, 1, 0, 0);
		push_item(OP_STEP, 0, 0, 0);

		// random phases, mostly small grids
		for (int ph = 0; ph < 9; ph++) begin
			push_reg(CFG_BIRTH, $urandom_range(0, 511));
			push_reg(CFG_SURVIVE, $urandom_range(0, 511));
			sel = $urandom_range(0, 7);
			if (ph == 0) begin
				push_reg(CFG_ROWS, 128);
				push_reg(CFG_COLS, 2);
			end else if (sel == 0) begin
				push_reg(CFG_ROWS, $urandom_range(0, 255));
				push_reg(CFG_COLS, $urandom_range(0, 3));
			end else begin
				push_reg(CFG_ROWS, $urandom_range(1, 10));
				push_reg(CFG_COLS, $urandom_range(1, 20));
			end
			n = $urandom_range(7, 11);
			for (int k = 0; k < n; k++) begin
				sel = $urandom_range(0, 19);
				if (sel < 10) o = OP_WRITE;
				else if (sel < 15) o = OP_READ;
				else if (sel < 19) o = OP_STEP;
				else o = OP_NONE;
				push_item(o, $urandom_range(0, 127), $urandom_range(0, 255),
					$urandom_range(0, 1));
			end
			// hold the sender off until every result is back
			if (ph == 4) push_drain();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_entries.size() > 0 || in_valid || cfg_valid || expected_cells.size() > 0)
			@(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < 40) begin
			@(posedge clk);
			wait_cycles++;
		end
		$display("covered %0d transactions (%0d generation steps), %0d register writes",
			items_sent, steps_sent, regs_written);
		$display("checked %0d results against the mirror grid", results_seen);
		if (errors == 0 && expected_cells.size() == 0)
			$display("** life_like_automaton_generation_unit: PASSED **");
		else
			$display("** life_like_automaton_generation_unit: FAILED **");
		$finish;
	end

endmodule
